FILE: hdl/dge_pkg.sv
// ----------------------------------------------------------------------------
// dge_pkg
// Shared widths, constants, command and status types, and the G.711 segment
// encoders of the decimating G.711 encoder.
// ----------------------------------------------------------------------------
package dge_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 18;
    localparam int MAG_W       = 17;
    localparam int RECIP_W     = 16;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 17;
    localparam int CODE_W      = 8;
    localparam int MODE_W      = 2;
    localparam int GAIN_W      = 4;
    localparam int SHIFTED_W   = SAMPLE_W + 15;
    localparam int FILT_W      = 32;
    localparam int COEF_W      = 16;
    localparam int FPROD_W     = FILT_W + COEF_W;
    localparam int YSUM_W      = 35;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    // Group of three samples per result.
    localparam int DECIM_FACTOR = 3;
    localparam logic [1:0] LAST_PHASE = 2'(DECIM_FACTOR - 1);

    // Division by three: 43691 = ceil(2^17 / 3), exact for magnitudes below 2^17.
    localparam logic [RECIP_W-1:0] RECIP3 = 16'd43691;

    // De-emphasis coefficients.
    localparam logic signed [COEF_W-1:0] DEEMPH_FB = 16'sd25889;
    localparam logic signed [COEF_W-1:0] DEEMPH_FF = 16'sd6878;

    // Codec modes.
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MULAW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALAW  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CODEC_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEMPH_EN  = 2'd2;

    // G.711 constants.
    localparam logic [7:0]  MU_MASK_POS = 8'hFF;
    localparam logic [7:0]  MU_MASK_NEG = 8'h7F;
    localparam logic [7:0]  A_MASK_POS  = 8'hD5;
    localparam logic [7:0]  A_MASK_NEG  = 8'h55;
    localparam logic [7:0]  SEG_OVF     = 8'h7F;
    localparam logic [13:0] MU_CLIP     = 14'd8159;
    localparam logic [13:0] MU_BIAS     = 14'd33;
    localparam logic [3:0]  NO_SEG      = 4'd8;

    localparam logic [13:0] MU_SEG_END [8] = '{
        14'h003F, 14'h007F, 14'h00FF, 14'h01FF,
        14'h03FF, 14'h07FF, 14'h0FFF, 14'h1FFF
    };
    localparam logic [11:0] A_SEG_END [8] = '{
        12'h01F, 12'h03F, 12'h07F, 12'h0FF,
        12'h1FF, 12'h3FF, 12'h7FF, 12'hFFF
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div;
        logic avg;
        logic fb;
        logic upd;
        logic ff;
        logic sat;
        logic enc;
    } dge_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_in_group;
        logic filter_on;
        logic out_free;
    } dge_sts_t;

    // Saturate a wide signed value to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [YSUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 35'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -35'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // G.711 mu-law encoder.
    function automatic logic [7:0] mu_encode(input logic signed [SAMPLE_W-1:0] pcm);
        logic signed [13:0] v;
        logic [13:0] mag;
        logic [7:0]  mask;
        logic [3:0]  seg;
        logic [13:0] sh;
        logic [7:0]  code;
        v = pcm[15:2];
        if (v[13]) begin
            mag  = 14'(-v);
            mask = MU_MASK_NEG;
        end else begin
            mag  = v;
            mask = MU_MASK_POS;
        end
        if (mag > MU_CLIP) begin
            mag = MU_CLIP;
        end
        mag = mag + MU_BIAS;
        seg = NO_SEG;
        for (int i = 7; i >= 0; i--) begin
            if (mag <= MU_SEG_END[i]) begin
                seg = 4'(i);
            end
        end
        sh = mag >> (seg + 4'd1);
        if (seg == NO_SEG) begin
            code = SEG_OVF ^ mask;
        end else begin
            code = {1'b0, seg[2:0], sh[3:0]} ^ mask;
        end
        return code;
    endfunction

    // G.711 A-law encoder.
    function automatic logic [7:0] a_encode(input logic signed [SAMPLE_W-1:0] pcm);
        logic signed [12:0] v;
        logic [11:0] mag;
        logic [7:0]  mask;
        logic [3:0]  seg;
        logic [11:0] sh;
        logic [7:0]  code;
        v = pcm[15:3];
        if (v[12]) begin
            // Ones' complement gives -v - 1 for a negative value.
            mag  = ~v[11:0];
            mask = A_MASK_NEG;
        end else begin
            mag  = v[11:0];
            mask = A_MASK_POS;
        end
        seg = NO_SEG;
        for (int i = 7; i >= 0; i--) begin
            if (mag <= A_SEG_END[i]) begin
                seg = 4'(i);
            end
        end
        if (seg < 4'd2) begin
            sh = mag >> 1;
        end else begin
            sh = mag >> seg;
        end
        if (seg == NO_SEG) begin
            code = SEG_OVF ^ mask;
        end else begin
            code = {1'b0, seg[2:0], sh[3:0]} ^ mask;
        end
        return code;
    endfunction

endpackage

FILE: hdl/decimate_deemph_g711_encoder.sv
// ----------------------------------------------------------------------------
// decimate_deemph_g711_encoder
// Averages each group of three samples and encodes the average as a G.711
// mu-law or A-law byte (zero in raw mode), with optional gain shift and de-emphasis.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | s_sample, s_buffer_end
//  m_      | out       | m_valid / m_ready  | m_companded_code, m_decimated_sample
//  cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
//  The first and second items of a group are taken back to back.
//  The last item of a group holds s_ready low while the controller walks
//  through the divide, average, saturate and encode steps, with feedback
//  multiply, state update and feed-forward multiply steps added when
//  de-emphasis is on in a companding mode.
//  A result waiting in the output register does not stop new items; a
//  second result waits in the encode step until the first one is taken.
//  Reset is synchronous and active low; there is no clearing pass.
// ----------------------------------------------------------------------------
module decimate_deemph_g711_encoder
    import dge_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SAMPLE_W-1:0]  s_sample,
    input  logic                        s_buffer_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [CODE_W-1:0]           m_companded_code,
    output logic signed [SAMPLE_W-1:0]  m_decimated_sample,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    dge_cmd_t cmd;
    dge_sts_t sts;

    dge_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dge_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_sample           (s_sample),
        .s_buffer_end       (s_buffer_end),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .cmd                (cmd),
        .sts                (sts),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_companded_code   (m_companded_code),
        .m_decimated_sample (m_decimated_sample)
    );

endmodule

FILE: hdl/dge_ctrl.sv
// ----------------------------------------------------------------------------
// dge_ctrl
// Controller state machine: takes samples, then steps a completed group
// through division, optional de-emphasis, saturation and encoding.
// ----------------------------------------------------------------------------
module dge_ctrl
    import dge_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dge_sts_t sts,
    output dge_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_AVG  = 8'b0000_0100,
        ST_FB   = 8'b0000_1000,
        ST_UPD  = 8'b0001_0000,
        ST_FF   = 8'b0010_0000,
        ST_SAT  = 8'b0100_0000,
        ST_ENC  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: only the last item of a group starts the processing run.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.last_in_group) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                state_next = ST_AVG;
            end
            ST_AVG: begin
                state_next = sts.filter_on ? ST_FB : ST_SAT;
            end
            ST_FB: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                state_next = ST_FF;
            end
            ST_FF: begin
                state_next = ST_SAT;
            end
            ST_SAT: begin
                state_next = ST_ENC;
            end
            ST_ENC: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands decoded from the state.
    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.accept = (state_reg == ST_IDLE) && s_valid;
    assign cmd.div    = (state_reg == ST_DIV);
    assign cmd.avg    = (state_reg == ST_AVG);
    assign cmd.fb     = (state_reg == ST_FB);
    assign cmd.upd    = (state_reg == ST_UPD);
    assign cmd.ff     = (state_reg == ST_FF);
    assign cmd.sat    = (state_reg == ST_SAT);
    assign cmd.enc    = (state_reg == ST_ENC) && sts.out_free;

endmodule

FILE: hdl/dge_datapath.sv
// ----------------------------------------------------------------------------
// dge_datapath
// Configuration registers, group accumulator, divide-by-three, de-emphasis
// filter, saturation, G.711 encoding and the output register.
// ----------------------------------------------------------------------------
module dge_datapath
    import dge_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic signed [SAMPLE_W-1:0]  s_sample,
    input  logic                        s_buffer_end,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  dge_cmd_t                    cmd,
    output dge_sts_t                    sts,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [CODE_W-1:0]           m_companded_code,
    output logic signed [SAMPLE_W-1:0]  m_decimated_sample
);

    logic [MODE_W-1:0]          mode_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic                       deemph_reg;
    logic [1:0]                 phase_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    grp_reg;
    logic                       neg_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [FPROD_W-1:0]  fb_prod_reg;
    logic signed [FILT_W-1:0]   filt_reg;
    logic signed [FPROD_W-1:0]  ff_prod_reg;
    logic signed [SAMPLE_W-1:0] pcm_reg;
    logic                       out_valid_reg;
    logic [CODE_W-1:0]          out_code_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;

    logic signed [SUM_W-1:0]     sum_add;
    logic [MAG_W-1:0]            grp_mag;
    logic [SAMPLE_W-1:0]         quot;
    logic signed [SHIFTED_W-1:0] shifted;
    logic signed [YSUM_W-1:0]    y_sum;
    logic [CODE_W-1:0]           code;
    logic                        companding;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_MULAW;
            gain_reg   <= '0;
            deemph_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CODEC_MODE: mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_GAIN_SHIFT: gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_DEEMPH_EN:  deemph_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign companding = (mode_reg == MODE_MULAW) || (mode_reg == MODE_ALAW);

    // Group accumulator; a buffer end before the last item drops the group.
    assign sum_add = sum_reg + {{(SUM_W-SAMPLE_W){s_sample[SAMPLE_W-1]}}, s_sample};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            sum_reg   <= '0;
        end else if (cmd.accept) begin
            if (phase_reg == LAST_PHASE || s_buffer_end) begin
                phase_reg <= '0;
                sum_reg   <= '0;
            end else begin
                phase_reg <= phase_reg + 2'd1;
                sum_reg   <= sum_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && phase_reg == LAST_PHASE) begin
            grp_reg <= sum_add;
        end
    end

    // Division by three on the magnitude, truncating toward zero.
    assign grp_mag = grp_reg[SUM_W-1] ? MAG_W'(-grp_reg) : MAG_W'(grp_reg);
    assign quot    = prod_reg[PROD_W-1:RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (cmd.div) begin
            neg_reg  <= grp_reg[SUM_W-1];
            prod_reg <= grp_mag * RECIP3;
        end
        if (cmd.avg) begin
            avg_reg <= neg_reg ? SAMPLE_W'(-quot) : quot;
        end
    end

    // Gain shift of the average.
    assign shifted = {{(SHIFTED_W-SAMPLE_W){avg_reg[SAMPLE_W-1]}}, avg_reg} <<< gain_reg;

    // De-emphasis: feedback product, state update, feed-forward product.
    always_ff @(posedge aclk) begin
        if (cmd.fb) begin
            x_reg       <= shifted[SAMPLE_W-1:0];
            fb_prod_reg <= filt_reg * DEEMPH_FB;
        end
        if (cmd.ff) begin
            ff_prod_reg <= filt_reg * DEEMPH_FF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (cmd.upd) begin
            filt_reg <= {{(FILT_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg}
                        + fb_prod_reg[FILT_W+14:15];
        end
    end

    // Filter output scaling and saturation.
    assign y_sum = {ff_prod_reg[FPROD_W-1], ff_prod_reg[FPROD_W-1:14]}
                 + {{2{ff_prod_reg[FPROD_W-1]}}, ff_prod_reg[FPROD_W-1:15]};

    always_ff @(posedge aclk) begin
        if (cmd.sat) begin
            if (sts.filter_on) begin
                pcm_reg <= sat16(y_sum);
            end else begin
                pcm_reg <= sat16({{(YSUM_W-SHIFTED_W){shifted[SHIFTED_W-1]}}, shifted});
            end
        end
    end

    // Encoding.
    always_comb begin
        priority if (mode_reg == MODE_MULAW) begin
            code = mu_encode(pcm_reg);
        end else if (mode_reg == MODE_ALAW) begin
            code = a_encode(pcm_reg);
        end else begin
            code = '0;
        end
    end

    // Output register: holds one item until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.enc) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enc) begin
            out_code_reg   <= code;
            out_sample_reg <= avg_reg;
        end
    end

    assign sts.last_in_group = (phase_reg == LAST_PHASE);
    assign sts.filter_on     = deemph_reg && companding;
    assign sts.out_free      = !out_valid_reg || m_ready;

    assign m_valid            = out_valid_reg;
    assign m_companded_code   = out_code_reg;
    assign m_decimated_sample = out_sample_reg;

endmodule

FILE: hdl/dge_checker.sv
// ----------------------------------------------------------------------------
// dge_checker
// Port-level checks of the decimating G.711 encoder, attached by bind.
// ----------------------------------------------------------------------------
module dge_checker
    import dge_pkg::*;
(
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_buffer_end,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [CODE_W-1:0]           m_companded_code,
    input logic signed [SAMPLE_W-1:0]  m_decimated_sample,
    input logic                        cfg_we,
    input logic [CFG_IDX_W-1:0]        cfg_index,
    input logic [CFG_DATA_W-1:0]       cfg_data
);

    logic [MODE_W-1:0] mode_sh_reg;
    logic [1:0]        phase_sh_reg;
    logic              s_take;
    logic              pass_through;

    assign s_take       = s_valid && s_ready;
    assign pass_through = !(mode_sh_reg == MODE_MULAW || mode_sh_reg == MODE_ALAW);

    // Shadow of the codec mode and of the position within a group.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_sh_reg  <= MODE_MULAW;
            phase_sh_reg <= '0;
        end else begin
            if (cfg_we && cfg_index == CFG_CODEC_MODE) begin
                mode_sh_reg <= cfg_data[MODE_W-1:0];
            end
            if (s_take) begin
                if (phase_sh_reg == LAST_PHASE || s_buffer_end) begin
                    phase_sh_reg <= '0;
                end else begin
                    phase_sh_reg <= phase_sh_reg + 2'd1;
                end
            end
        end
    end

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_companded_code)
                                && $stable(m_decimated_sample))
        else $error("result item changed while stalled");

    // Without companding the code byte is zero.
    a_raw_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && pass_through |-> m_companded_code == '0)
        else $error("non-zero code byte without companding");

    // Items inside a group are taken back to back.
    a_mid_group: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && phase_sh_reg != LAST_PHASE |=> s_ready)
        else $error("input stalled inside a group");

    // The last item of a group starts processing.
    a_group_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && phase_sh_reg == LAST_PHASE |=> !s_ready)
        else $error("input not held off after a complete group");

    // A new result appears only at the end of a processing run.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a processing run");

endmodule

bind decimate_deemph_g711_encoder dge_checker u_dge_checker (.*);
